### hw/rtl/cwc_pkg.sv
package cwc_pkg;

    localparam int DEF_FRAC_BITS       = 12;
    localparam int DEF_WINDOW_INT_BITS = 12;

    localparam int BETA_BITS     = 12;
    localparam int FACTOR_W      = BETA_BITS + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int IN_FLIGHT_W   = 16;
    localparam int SEQ_W         = 32;
    localparam int THR_RESET_INT = 128;

    localparam logic [FACTOR_W-1:0] DEF_DECREASE_FACTOR = FACTOR_W'(2048);

    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_NACK    = 2'd3;

    localparam logic [1:0] MODE_AIMD = 2'd0;
    localparam logic [1:0] MODE_ECP  = 2'd1;
    localparam logic [1:0] MODE_NONE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECP_FAST_INCREASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_TO_INITIAL  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_GROW,
        S_SHRINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic bookkeep;
        logic rp_update;
        logic shrink;
        logic grow_const;
        logic div_start;
        logic div_step;
        logic grow_recip;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] mode;
        logic       nack_cong;
        logic       fast;
        logic       win_lt_thr;
        logic       shrink_ok;
        logic       div_last;
        logic       out_free;
    } t_status;

endpackage

### hw/rtl/cwc_ctrl.sv
module cwc_ctrl
    import cwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.bookkeep = 1'b1;
                n_state        = S_DONE;
                case (i_status.opcode)
                    OP_DATA: begin
                        if (i_status.mode == MODE_AIMD) begin
                            if (i_status.win_lt_thr) begin
                                o_cmd.grow_const = 1'b1;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end else if (i_status.mode == MODE_ECP) begin
                            if (i_status.fast) begin
                                o_cmd.grow_const = 1'b1;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end
                    end
                    OP_TIMEOUT: begin
                        if (i_status.shrink_ok) begin
                            o_cmd.rp_update = 1'b1;
                            n_state         = S_SHRINK;
                        end
                    end
                    OP_NACK: begin
                        if (i_status.mode == MODE_AIMD && i_status.nack_cong &&
                            i_status.shrink_ok) begin
                            o_cmd.rp_update = 1'b1;
                            n_state         = S_SHRINK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                o_cmd.grow_recip = 1'b1;
                n_state          = S_DONE;
            end
            S_SHRINK: begin
                o_cmd.shrink = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/cwc_datapath.sv
module cwc_datapath
    import cwc_pkg::*;
#(
    parameter  int FRAC_BITS       = DEF_FRAC_BITS,
    parameter  int WINDOW_INT_BITS = DEF_WINDOW_INT_BITS,
    localparam int WIN_W           = WINDOW_INT_BITS + FRAC_BITS,
    localparam int CFG_W           = (WIN_W > FACTOR_W) ? WIN_W : FACTOR_W,
    localparam int OUT_W           = 2 * WIN_W + IN_FLIGHT_W + 1,
    localparam int OUT_TW          = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic [SEQ_W-1:0]     i_in_seq,
    input  logic [3:0]           i_in_user,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_TW-1:0]    o_out_data
);

    localparam int NUM_W = 2 * FRAC_BITS + 1;
    localparam int MAX_W = (NUM_W > WIN_W) ? NUM_W : WIN_W;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int CMP_W = (IN_FLIGHT_W > WINDOW_INT_BITS) ? IN_FLIGHT_W : WINDOW_INT_BITS;
    localparam int PROD_W = WIN_W + FACTOR_W;

    localparam logic [WIN_W-1:0] WIN_MAX      = {WIN_W{1'b1}};
    localparam logic [WIN_W-1:0] FX_ONE       = WIN_W'(1) << FRAC_BITS;
    localparam logic [WIN_W-1:0] THR_RESET    = WIN_W'(THR_RESET_INT) << FRAC_BITS;
    localparam logic [WIN_W-1:0] INC_AIMD_FAV = WIN_W'((6 << FRAC_BITS) / 5);
    localparam logic [WIN_W-1:0] INC_ECP_FAV  = WIN_W'(3) << (FRAC_BITS - 2);
    localparam logic [WIN_W-1:0] INC_ECP      = WIN_W'(1) << (FRAC_BITS - 1);
    localparam logic [NUM_W-1:0] NUM_ONE      = NUM_W'(1) << (2 * FRAC_BITS);
    localparam logic [NUM_W-1:0] NUM_FAV      = NUM_W'(5) << (2 * FRAC_BITS - 2);
    localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(NUM_W - 1);
    localparam logic [IN_FLIGHT_W-1:0] IN_FLIGHT_MAX = {IN_FLIGHT_W{1'b1}};

    logic [1:0]           r_mode;
    logic [FACTOR_W-1:0]  r_factor;
    logic                 r_fast;
    logic [WIN_W-1:0]     r_init;
    logic                 r_floor;

    logic [1:0]           r_op;
    logic [SEQ_W-1:0]     r_seq;
    logic                 r_fav;
    logic                 r_cong;

    logic [WIN_W-1:0]       r_window;
    logic [WIN_W-1:0]       r_thr;
    logic [IN_FLIGHT_W-1:0] r_in_flight;
    logic [SEQ_W-1:0]       r_highest;
    logic [SEQ_W-1:0]       r_recovery;
    logic [SEQ_W-1:0]       r_next_seq;

    logic [PROD_W-1:0]    r_prod;
    logic [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]     r_quo;
    logic [WIN_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div_cnt;

    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out;

    logic [WIN_W:0]       trial;
    logic                 trial_ge;
    logic [WIN_W-1:0]     const_inc;
    logic [WIN_W-1:0]     recip_inc;
    logic [WIN_W-1:0]     grow_inc;
    logic [WIN_W:0]       grow_sum;
    logic [WIN_W-1:0]     grow_win;
    logic [WIN_W-1:0]     win_half;
    logic [WIN_W+2:0]     win_x7;
    logic [WIN_W:0]       beta_raw;
    logic [WIN_W-1:0]     beta_win;
    logic [WIN_W-1:0]     cut_win;
    logic [WIN_W-1:0]     floor_win;
    logic                 may_send;
    logic                 out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_AIMD;
            r_factor <= DEF_DECREASE_FACTOR;
            r_fast   <= 1'b1;
            r_init   <= FX_ONE;
            r_floor  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALGORITHM_MODE:    r_mode   <= i_cfg_data[1:0];
                CFG_DECREASE_FACTOR:   r_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_ECP_FAST_INCREASE: r_fast   <= i_cfg_data[0];
                CFG_INITIAL_WINDOW:    r_init   <= i_cfg_data[WIN_W-1:0];
                CFG_FLOOR_TO_INITIAL:  r_floor  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && i_cmd.in_ready) begin
            r_op   <= i_in_user[1:0];
            r_fav  <= i_in_user[2];
            r_cong <= i_in_user[3];
            r_seq  <= i_in_seq;
        end
    end

    // divider step: restoring, one quotient bit per cycle
    assign trial    = {r_rem, r_num[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, r_window});

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_window) * PROD_W'(r_factor);
        if (i_cmd.div_start) begin
            r_num     <= r_fav ? NUM_FAV : NUM_ONE;
            r_quo     <= '0;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num     <= {r_num[NUM_W-2:0], 1'b0};
            r_quo     <= {r_quo[NUM_W-2:0], trial_ge};
            r_rem     <= trial_ge ? WIN_W'(trial - {1'b0, r_window}) : trial[WIN_W-1:0];
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        if (r_mode == MODE_AIMD) begin
            const_inc = r_fav ? INC_AIMD_FAV : FX_ONE;
        end else begin
            const_inc = r_fav ? INC_ECP_FAV : INC_ECP;
        end
        if (r_window == '0 || MAX_W'(r_quo) > MAX_W'(WIN_MAX)) begin
            recip_inc = WIN_MAX;
        end else begin
            recip_inc = r_quo[WIN_W-1:0];
        end
        grow_inc = i_cmd.grow_recip ? recip_inc : const_inc;
        grow_sum = {1'b0, r_window} + {1'b0, grow_inc};
        grow_win = grow_sum[WIN_W] ? WIN_MAX : grow_sum[WIN_W-1:0];

        win_half = {1'b0, r_window[WIN_W-1:1]};
        win_x7   = {r_window, 3'b000} - {3'b000, r_window};
        beta_raw = r_prod[PROD_W-1:BETA_BITS];
        beta_win = beta_raw[WIN_W] ? WIN_MAX : beta_raw[WIN_W-1:0];

        case (r_mode)
            MODE_AIMD: cut_win = (r_op == OP_NACK) ? win_half : beta_win;
            MODE_ECP:  cut_win = (r_op == OP_NACK) ? win_x7[WIN_W+2:3] : win_half;
            default:   cut_win = r_window;
        endcase

        if (r_floor && cut_win < r_init) begin
            floor_win = r_init;
        end else if (cut_win < FX_ONE) begin
            floor_win = FX_ONE;
        end else begin
            floor_win = cut_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= FX_ONE;
            r_thr       <= THR_RESET;
            r_in_flight <= '0;
            r_highest   <= '0;
            r_recovery  <= '0;
            r_next_seq  <= '0;
        end else begin
            if (i_cmd.bookkeep) begin
                case (r_op)
                    OP_SEND: begin
                        if (r_in_flight != IN_FLIGHT_MAX) begin
                            r_in_flight <= r_in_flight + IN_FLIGHT_W'(1);
                        end
                        r_next_seq <= r_seq + SEQ_W'(1);
                    end
                    OP_DATA: begin
                        if (r_in_flight != '0) begin
                            r_in_flight <= r_in_flight - IN_FLIGHT_W'(1);
                        end
                        if (r_highest < r_seq) begin
                            r_highest <= r_seq;
                        end
                    end
                    OP_TIMEOUT: begin
                        if (r_in_flight != '0) begin
                            r_in_flight <= r_in_flight - IN_FLIGHT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.rp_update) begin
                r_recovery <= r_next_seq;
            end
            if (i_cmd.grow_const || i_cmd.grow_recip) begin
                r_window <= grow_win;
            end
            if (i_cmd.shrink) begin
                r_window <= floor_win;
                if (r_mode == MODE_AIMD) begin
                    r_thr <= cut_win;
                end
            end
        end
    end

    assign may_send = (CMP_W'(r_in_flight) < CMP_W'(r_window[WIN_W-1:FRAC_BITS]));
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= {may_send, r_in_flight, r_thr, r_window};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_TW'(r_out);

    assign o_status.opcode     = r_op;
    assign o_status.mode       = r_mode;
    assign o_status.nack_cong  = r_cong;
    assign o_status.fast       = r_fast;
    assign o_status.win_lt_thr = (r_window < r_thr);
    assign o_status.shrink_ok  = (r_highest > r_recovery);
    assign o_status.div_last   = (r_div_cnt == CNT_LAST);
    assign o_status.out_free   = out_free;

endmodule

### hw/rtl/congestion_window_controller_unit.sv
// Congestion window controller: AIMD window with slow start, ECP window, or no growth (mode none).
// Input stream: one item per packet event. tuser carries opcode (send, data,
// timeout, nack), priority class and congestion-nack flag; tdata carries the
// sequence number. Every accepted item yields exactly one result on the
// output stream: window, slow-start threshold, in-flight count and may_send.
// Configuration channel: register index plus data, always ready; write it
// only while no item is in progress.
// A send, a constant-step data item, and a timeout or nack without a window
// cut pass the EXEC and DONE states; a window cut adds SHRINK, and a
// reciprocal increase adds DIV and GROW, in which the restoring divider
// produces one quotient bit per cycle.
// One item is worked on at a time; the next is accepted in the cycle after the
// result is registered. The output register frees the core: a new item is
// taken while a result waits, and a finished result waits in the core only
// if the receiver still stalls the previous one. Reset (synchronous, active
// low) restores window to 1.0, threshold to 128.0, counters and sequences to
// zero and the configuration registers to their defaults.
module congestion_window_controller_unit
    import cwc_pkg::*;
#(
    parameter  int FRAC_BITS       = DEF_FRAC_BITS,
    parameter  int WINDOW_INT_BITS = DEF_WINDOW_INT_BITS,
    localparam int WIN_W           = WINDOW_INT_BITS + FRAC_BITS,
    localparam int CFG_W           = (WIN_W > FACTOR_W) ? WIN_W : FACTOR_W,
    localparam int OUT_W           = 2 * WIN_W + IN_FLIGHT_W + 1,
    localparam int OUT_TW          = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // seq_number
    input  logic [SEQ_W-1:0]     i_s_axis_tdata,
    // opcode[1:0], priority_class, nack_congestion
    input  logic [3:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // window_now, threshold_now, in_flight_now, may_send, zero pad
    output logic [OUT_TW-1:0]    o_m_axis_tdata
);

    t_cmd    cmd;
    t_status status;

    cwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cwc_datapath #(
        .FRAC_BITS       (FRAC_BITS),
        .WINDOW_INT_BITS (WINDOW_INT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_seq    (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = cmd.in_ready;

endmodule
